>>> rtl/core/hdlcdf_pkg.sv
// Package: shared types and constants for the byte-unstuffing deframer.
`default_nettype none

package hdlcdf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned POS_MAX     = (1 << POS_W) - 1;
  localparam int unsigned MAX_FRAME_D = 2048;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] CODE_FLAG = 8'h5E;
  localparam logic [BYTE_W-1:0] CODE_ESC  = 8'h5D;

  localparam logic [BYTE_W-1:0] FLAG_RST    = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'h7D;
  localparam logic [POS_W-1:0]  MAX_LEN_RST = 12'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG    = 2'd0,
    REG_ESCAPE  = 2'd1,
    REG_MAX_LEN = 2'd2,
    REG_NONE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_DATA      = 3'd1,
    ST_EOF       = 3'd2,
    ST_BAD_START = 3'd3,
    ST_BAD_ESC   = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/hdlcdf_in_if.sv
// Interface: received-byte channel.
`default_nettype none

interface hdlcdf_in_if
  import hdlcdf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hdlcdf_out_if.sv
// Interface: result channel.
`default_nettype none

interface hdlcdf_out_if
  import hdlcdf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  position;

  modport source (output valid, output status, output data_byte, output position,
                  input ready);
  modport sink   (input valid, input status, input data_byte, input position,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/hdlcdf_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none

interface hdlcdf_cfg_if
  import hdlcdf_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [POS_W-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hdlcdf_skid.sv
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module hdlcdf_skid
  import hdlcdf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire result_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output result_t      pop_data
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_d_r, main_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    push;
  logic    pop;

  assign push_ready = !skid_v_r;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_d_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && pop_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      if (skid_v_r) begin
        // drain the skid beat into the result register
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_d_nxt = push_data;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_d_nxt = push_data;
        main_v_nxt = 1'b1;
      end else begin
        // hold the beat while downstream stalls
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/hdlc_byte_unstuff_deframer.sv
// Byte-unstuffing HDLC deframer: one received byte in, one result out.
// Throughput: one byte per cycle while the skid register is empty; frame state updates in a
// single compare-and-count step. Each result is registered in the output buffer on acceptance.
// A two-entry output buffer lets input continue for one beat while the output stalls.
// Reset (synchronous, active low): out of frame, no escape pending, count zero,
// registers back to flag 0x7E, escape 0x7D, length limit 2048.
`default_nettype none

module hdlc_byte_unstuff_deframer
  import hdlcdf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MAX_FRAME_D
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  hdlcdf_in_if.sink     in_ch,
  hdlcdf_out_if.source  out_ch,
  hdlcdf_cfg_if.sink    cfg_ch
);

  localparam int unsigned CAP = (MAX_FRAME > POS_MAX) ? POS_MAX : MAX_FRAME;
  localparam logic [POS_W-1:0] CAP_V = POS_W'(CAP);

  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] escape_r, escape_nxt;
  logic [POS_W-1:0]  max_len_r, max_len_nxt;

  logic              in_frame_r, in_frame_nxt;
  logic              esc_pend_r, esc_pend_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;

  logic              in_acc;
  logic              buf_ready;
  logic [BYTE_W-1:0] b;
  logic [POS_W-1:0]  limit;
  logic              full;
  result_t           res;
  result_t           out_res;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = buf_ready;
  assign in_acc       = in_ch.valid && buf_ready;
  assign b            = in_ch.rx_byte;
  assign limit        = (max_len_r > CAP_V) ? CAP_V : max_len_r;
  assign full         = (count_r >= limit);

  always_comb begin
    flag_nxt    = flag_r;
    escape_nxt  = escape_r;
    max_len_nxt = max_len_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_FLAG:    flag_nxt    = cfg_ch.wdata[BYTE_W-1:0];
        REG_ESCAPE:  escape_nxt  = cfg_ch.wdata[BYTE_W-1:0];
        REG_MAX_LEN: max_len_nxt = cfg_ch.wdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt  = in_frame_r;
    esc_pend_nxt  = esc_pend_r;
    count_nxt     = count_r;
    res.status    = ST_NONE;
    res.data_byte = '0;
    res.position  = '0;
    if (!in_frame_r) begin
      if (b == flag_r) begin
        in_frame_nxt = 1'b1;
        esc_pend_nxt = 1'b0;
        count_nxt    = '0;
      end else begin
        res.status = ST_BAD_START;
      end
    end else if (b == flag_r) begin
      // flag wins, even with an escape pending
      res.status   = ST_EOF;
      res.position = count_r;
      in_frame_nxt = 1'b0;
      esc_pend_nxt = 1'b0;
      count_nxt    = '0;
    end else if (esc_pend_r && b != CODE_FLAG && b != CODE_ESC) begin
      // leave state alone, escape stays pending
      res.status   = ST_BAD_ESC;
      res.position = count_r;
    end else if (!esc_pend_r && b == escape_r) begin
      esc_pend_nxt = 1'b1;
    end else begin
      esc_pend_nxt = 1'b0;
      res.position = count_r;
      if (full) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.status = ST_DATA;
        if (!esc_pend_r) begin
          res.data_byte = b;
        end else if (b == CODE_FLAG) begin
          res.data_byte = flag_r;
        end else begin
          res.data_byte = escape_r;
        end
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r     <= FLAG_RST;
      escape_r   <= ESCAPE_RST;
      max_len_r  <= MAX_LEN_RST;
      in_frame_r <= 1'b0;
      esc_pend_r <= 1'b0;
      count_r    <= '0;
    end else begin
      flag_r    <= flag_nxt;
      escape_r  <= escape_nxt;
      max_len_r <= max_len_nxt;
      if (in_acc) begin
        in_frame_r <= in_frame_nxt;
        esc_pend_r <= esc_pend_nxt;
        count_r    <= count_nxt;
      end
    end
  end

  hdlcdf_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (buf_ready),
    .push_data  (res),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_res)
  );

  assign out_ch.status    = out_res.status;
  assign out_ch.data_byte = out_res.data_byte;
  assign out_ch.position  = out_res.position;

endmodule

`default_nettype wire
